// ===== src/integer_to_ascii_formatter_assert.svh =====
// Assertion macros used by the formatter back end.
// Each macro samples on clock and is disabled while reset is high.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ITA_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ITA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ita_pkg.sv =====
package ita_pkg;

   // Format commands
   localparam logic [1:0] CMD_SDEC = 2'd0;
   localparam logic [1:0] CMD_UDEC = 2'd1;
   localparam logic [1:0] CMD_LHEX = 2'd2;
   localparam logic [1:0] CMD_UHEX = 2'd3;

   // ASCII codes
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_LO_BASE = 8'h57;  // 'a' - 10
   localparam logic [7:0] CHAR_UP_BASE = 8'h37;  // 'A' - 10

   // Classification of one item, carried from front to back
   typedef struct packed {
      logic hex;
      logic upper;
      logic neg;
      logic pfx;
   } item_info_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_PFX0,
      ST_PFX1,
      ST_DIGIT
   } back_state_type;

   // Map one digit to its ASCII code
   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] dx;
      dx = {4'h0, d};
      if (d < 4'd10) begin
         return CHAR_ZERO + dx;
      end
      return (upper ? CHAR_UP_BASE : CHAR_LO_BASE) + dx;
   endfunction

   // Add-3 correction of one BCD digit before a shift
   function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
      return (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

endpackage

// ===== src/ita_front.sv =====
module ita_front #(
   parameter int DEC_WIDTH = 32,
   parameter int HEX_WIDTH = 64,
   parameter int MAG_W     = 64
) (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_command,
   input  logic [63:0]           req_value,
   input  logic                  req_want_prefix,
   input  logic                  q_full,
   output logic                  q_push,
   output ita_pkg::item_info_type q_info,
   output logic [MAG_W-1:0]      q_mag
);

   localparam int HEX_PAD = ((HEX_WIDTH + 3) / 4) * 4;

   logic                 is_hex;
   logic [DEC_WIDTH-1:0] dec_val;
   logic [DEC_WIDTH-1:0] dec_mag;
   logic [HEX_WIDTH-1:0] hex_val;

   // Accept while the queue has room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   // Classify the item and left-align its magnitude
   always_comb begin
      is_hex  = (req_command == ita_pkg::CMD_LHEX) || (req_command == ita_pkg::CMD_UHEX);
      dec_val = req_value[DEC_WIDTH-1:0];
      hex_val = req_value[HEX_WIDTH-1:0];

      q_info.hex   = is_hex;
      q_info.upper = (req_command == ita_pkg::CMD_UHEX);
      q_info.neg   = (req_command == ita_pkg::CMD_SDEC) && dec_val[DEC_WIDTH-1];
      q_info.pfx   = is_hex && req_want_prefix && (hex_val != '0);

      // Negation wraps the most negative value onto itself, its own magnitude
      dec_mag = q_info.neg ? (~dec_val + 1'b1) : dec_val;

      if (is_hex) begin
         q_mag = MAG_W'(hex_val) << (MAG_W - HEX_PAD);
      end else begin
         q_mag = MAG_W'(dec_mag) << (MAG_W - DEC_WIDTH);
      end
   end

endmodule

// ===== src/ita_queue.sv =====
module ita_queue #(
   parameter int DATA_W = 68
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              not_empty
);

   logic [DATA_W-1:0] mem [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        cnt_ff;
   logic [1:0]        cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/ita_back.sv =====
`include "integer_to_ascii_formatter_assert.svh"

module ita_back #(
   parameter int DEC_WIDTH = 32,
   parameter int HEX_WIDTH = 64,
   parameter int MAG_W     = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ita_pkg::item_info_type q_info,
   input  logic [MAG_W-1:0]       q_mag,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_char_out,
   output logic                   rsp_last
);

   localparam int HEX_DIGITS = (HEX_WIDTH + 3) / 4;
   localparam int DEC_DIGITS = (DEC_WIDTH * 77) / 256 + 1;
   localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int NDW        = $clog2(NDIG + 1);
   localparam int DIW        = $clog2(NDIG);
   localparam int CNT_W      = $clog2(MAG_W + 1);

   ita_pkg::back_state_type state_ff, state_in;
   ita_pkg::item_info_type  info_ff, info_in;
   logic [MAG_W-1:0]        mag_ff, mag_in, mag_step;
   logic [NDIG-1:0][3:0]    dig_ff, dig_in, dig_adj;
   logic [NDIG*4-1:0]       adj_flat;
   logic [NDIG*4-1:0]       dig_step;
   logic [NDW-1:0]          ndig_ff, ndig_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    grow;
   logic [DIW-1:0]          dig_idx;
   logic                    out_free;
   logic                    push;
   logic [7:0]              char_in;
   logic                    last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_char_ff;
   logic                    rsp_last_ff;
   logic                    in_conv;
   logic                    in_idle;
   logic                    ndig_ok;

   // One conversion step: double dabble for decimal, nibble shift for hex
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         dig_adj[i] = ita_pkg::bcd_adjust(dig_ff[i]);
      end
      adj_flat = dig_adj;
      if (info_ff.hex) begin
         dig_step = {dig_ff[NDIG-2:0], mag_ff[MAG_W-1 -: 4]};
         mag_step = mag_ff << 4;
      end else begin
         dig_step = {adj_flat[NDIG*4-2:0], mag_ff[MAG_W-1]};
         mag_step = mag_ff << 1;
      end
      // The digit count grows by at most one per step
      grow = 1'b0;
      for (int i = 1; i < NDIG; i++) begin
         if ((ndig_ff == NDW'(i)) && (dig_step[i*4 +: 4] != 4'd0)) begin
            grow = 1'b1;
         end
      end
   end

   assign dig_idx  = DIW'(ndig_ff - NDW'(1));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequence load, conversion and character emission
   always_comb begin
      state_in = state_ff;
      info_in  = info_ff;
      mag_in   = mag_ff;
      dig_in   = dig_ff;
      ndig_in  = ndig_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      push     = 1'b0;
      char_in  = ita_pkg::CHAR_ZERO;
      last_in  = 1'b0;
      unique case (state_ff)
         ita_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               info_in  = q_info;
               mag_in   = q_mag;
               dig_in   = '0;
               ndig_in  = NDW'(1);
               cnt_in   = q_info.hex ? CNT_W'(HEX_DIGITS - 1) : CNT_W'(DEC_WIDTH - 1);
               state_in = ita_pkg::ST_CONV;
            end
         end
         ita_pkg::ST_CONV: begin
            dig_in  = dig_step;
            mag_in  = mag_step;
            ndig_in = ndig_ff + NDW'(grow);
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (info_ff.neg) begin
                  state_in = ita_pkg::ST_SIGN;
               end else if (info_ff.pfx) begin
                  state_in = ita_pkg::ST_PFX0;
               end else begin
                  state_in = ita_pkg::ST_DIGIT;
               end
            end
         end
         ita_pkg::ST_SIGN: begin
            if (out_free) begin
               push     = 1'b1;
               char_in  = ita_pkg::CHAR_MINUS;
               state_in = ita_pkg::ST_DIGIT;
            end
         end
         ita_pkg::ST_PFX0: begin
            if (out_free) begin
               push     = 1'b1;
               char_in  = ita_pkg::CHAR_ZERO;
               state_in = ita_pkg::ST_PFX1;
            end
         end
         ita_pkg::ST_PFX1: begin
            if (out_free) begin
               push     = 1'b1;
               char_in  = ita_pkg::CHAR_X;
               state_in = ita_pkg::ST_DIGIT;
            end
         end
         ita_pkg::ST_DIGIT: begin
            if (out_free) begin
               push    = 1'b1;
               char_in = ita_pkg::digit_char(dig_ff[dig_idx], info_ff.upper);
               last_in = (ndig_ff == NDW'(1));
               if (last_in) begin
                  state_in = ita_pkg::ST_IDLE;
               end else begin
                  ndig_in = ndig_ff - NDW'(1);
               end
            end
         end
         default: begin
            state_in = ita_pkg::ST_IDLE;
         end
      endcase
   end

   // Output register: load on emit, drop once transferred
   always_comb begin
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ita_pkg::ST_IDLE;
         ndig_ff      <= NDW'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ndig_ff      <= ndig_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      info_ff <= info_in;
      mag_ff  <= mag_in;
      dig_ff  <= dig_in;
      if (push) begin
         rsp_char_ff <= char_in;
         rsp_last_ff <= last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

   assign in_conv = (state_ff == ita_pkg::ST_CONV);
   assign in_idle = (state_ff == ita_pkg::ST_IDLE);
   assign ndig_ok = (ndig_ff != '0) && (ndig_ff <= NDW'(NDIG));

   `ITA_ASSERT_NEXT(a_conv_runs, in_conv && (cnt_ff != '0), in_conv, "conversion ended early")
   `ITA_ASSERT_SAME(a_ndig_range, 1'b1, ndig_ok, "digit count out of range")
   `ITA_ASSERT_NEXT(a_last_idle, push && last_in, in_idle, "last character did not end the item")

endmodule

// ===== src/integer_to_ascii_formatter.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   command, value, want_prefix
// rsp_      out        rsp_valid/rsp_stall   char_out, last
//
// One item at a time in the back end: a load step, then conversion (decimal, one bit per cycle;
// hex, one nibble per cycle), then the characters: a minus sign or 0x prefix if any, then the digits.
// A two-entry queue lets the front accept items while the back works.
// Reset is synchronous and clears queue, state machine and output valid.
// A stalled result holds in the output register; the back waits until it is taken.
module integer_to_ascii_formatter #(
   parameter int DEC_WIDTH = 32,
   parameter int HEX_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_value,
   input  logic        req_want_prefix,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last
);

   localparam int HEX_PAD = ((HEX_WIDTH + 3) / 4) * 4;
   localparam int MAG_W   = (DEC_WIDTH > HEX_PAD) ? DEC_WIDTH : HEX_PAD;
   localparam int INFO_W  = $bits(ita_pkg::item_info_type);
   localparam int DATA_W  = INFO_W + MAG_W;

   logic                   q_full;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_valid;
   ita_pkg::item_info_type front_info;
   ita_pkg::item_info_type back_info;
   logic [MAG_W-1:0]       front_mag;
   logic [MAG_W-1:0]       back_mag;
   logic [DATA_W-1:0]      q_out;

   ita_front #(
      .DEC_WIDTH (DEC_WIDTH),
      .HEX_WIDTH (HEX_WIDTH),
      .MAG_W     (MAG_W)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_value       (req_value),
      .req_want_prefix (req_want_prefix),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_info          (front_info),
      .q_mag           (front_mag)
   );

   ita_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({front_info, front_mag}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .not_empty (q_valid)
   );

   // Split queue entry into classification and magnitude
   assign back_info = q_out[DATA_W-1 -: INFO_W];
   assign back_mag  = q_out[MAG_W-1:0];

   ita_back #(
      .DEC_WIDTH (DEC_WIDTH),
      .HEX_WIDTH (HEX_WIDTH),
      .MAG_W     (MAG_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_info       (back_info),
      .q_mag        (back_mag),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== tb/tb_integer_to_ascii_formatter.sv =====
// Expected text of every accepted number, one character per entry
class ascii_text_scoreboard;
   logic [7:0] char_q[$];
   logic       last_q[$];
   int         errors;

   function new();
      errors = 0;
   endfunction

   // Count a failure; print only the first few
   function void flag_error(string msg);
      errors++;
      if (errors <= 10) begin
         $display("ERROR: %s", msg);
      end
   endfunction

   // Build the characters of one accepted request and queue them
   function void note_request(logic [1:0] cmd, logic [63:0] value, logic pfx);
      logic [7:0]  text[$];
      logic [7:0]  rev[$];
      logic [63:0] mag;
      logic [31:0] low;
      string       digit_set;
      if (cmd == ita_pkg::CMD_SDEC || cmd == ita_pkg::CMD_UDEC) begin
         // decimal forms read only the low 32 bits
         low = value[31:0];
         mag = {32'd0, low};
         if (cmd == ita_pkg::CMD_SDEC && low[31]) begin
            // negate within 32 bits; the most negative value maps to itself
            mag = {32'd0, ~low + 32'd1};
            text.push_back(ita_pkg::CHAR_MINUS);
         end
         do begin
            rev.push_back(ita_pkg::CHAR_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
         end while (mag != 64'd0);
      end else begin
         digit_set = (cmd == ita_pkg::CMD_UHEX) ? "0123456789ABCDEF" : "0123456789abcdef";
         mag = value;
         // prefix is always lower case and never shown for zero
         if (pfx && value != 64'd0) begin
            text.push_back(ita_pkg::CHAR_ZERO);
            text.push_back(ita_pkg::CHAR_X);
         end
         do begin
            rev.push_back(8'(digit_set[int'(mag[3:0])]));
            mag = mag >> 4;
         end while (mag != 64'd0);
      end
      for (int i = rev.size() - 1; i >= 0; i--) begin
         text.push_back(rev[i]);
      end
      foreach (text[i]) begin
         char_q.push_back(text[i]);
         last_q.push_back(i == text.size() - 1);
      end
   endfunction

   // Compare one accepted character with the oldest expected one
   function void check_char(logic [7:0] got_char, logic got_last);
      logic [7:0] exp_char;
      logic       exp_last;
      if (char_q.size() == 0) begin
         flag_error($sformatf("unexpected char %h last %b", got_char, got_last));
         return;
      end
      exp_char = char_q.pop_front();
      exp_last = last_q.pop_front();
      if (got_char !== exp_char || got_last !== exp_last) begin
         flag_error($sformatf("char exp %h last %b, got char %h last %b",
                              exp_char, exp_last, got_char, got_last));
      end
   endfunction

   function bit drained();
      return char_q.size() == 0;
   endfunction
endclass

module tb_integer_to_ascii_formatter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_ITEMS  = 82;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = ita_pkg::CMD_SDEC;
   logic [63:0] req_value = 64'd0;
   logic        req_want_prefix = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_req = 1'b0;
   int quiet_cycles = 0;

   ascii_text_scoreboard text_sb = new();

   integer_to_ascii_formatter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_value      (req_value),
      .req_want_prefix(req_want_prefix),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_out   (rsp_char_out),
      .rsp_last       (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predict on every input transfer, check every output transfer
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         text_sb.note_request(req_command, req_value, req_want_prefix);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         text_sb.check_char(rsp_char_out, rsp_last);
      end
   end

   // Watchdog: end the run after too long without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Receiver: random stall, or a long hold when requested
   initial begin
      @(negedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
            @(negedge clock);
         end
      end
   end

   // Offer one request and hold it until the transfer
   task automatic send_item(input logic [1:0] cmd, input logic [63:0] value,
                            input logic pfx);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_value       <= value;
      req_want_prefix <= pfx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected character has come
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (!text_sb.drained()) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mix of full-width, short, boundary and sign-edge values
   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      case ($urandom_range(5))
         0: ;
         1: v = v >> $urandom_range(63);
         2: v = 64'($urandom_range(20));
         3: v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
         4: v = {v[63:32], 1'b1, v[30:0]};
         default: begin
            case ($urandom_range(4))
               0: v = 64'h0000_0000_8000_0000;
               1: v = '1;
               2: v = {v[63:32], 32'hFFFF_FFFF};
               3: v = 64'h8000_0000_0000_0000;
               default: v = {v[63:32], 32'h7FFF_FFFF};
            endcase
         end
      endcase
      return v;
   endfunction

   initial begin
      int send_pct[4];
      int recv_pct[4];
      send_pct = '{0, 48, 0, 13};
      recv_pct = '{0, 0, 48, 13};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: signed decimal edges, upper bits ignored
      send_item(ita_pkg::CMD_SDEC, 64'd0, 1'b0);
      send_item(ita_pkg::CMD_SDEC, 64'h0000_0000_8000_0000, 1'b0);
      send_item(ita_pkg::CMD_SDEC, 64'h0000_0000_7FFF_FFFF, 1'b0);
      send_item(ita_pkg::CMD_SDEC, 64'h0000_0000_FFFF_FFFF, 1'b0);
      send_item(ita_pkg::CMD_SDEC, 64'hFFFF_FFFF_0000_0001, 1'b0);
      send_item(ita_pkg::CMD_SDEC, 64'h1234_5678_FFFF_FFF6, 1'b1);
      // Unsigned decimal; prefix has no effect
      send_item(ita_pkg::CMD_UDEC, 64'd0, 1'b1);
      send_item(ita_pkg::CMD_UDEC, 64'h0000_0000_FFFF_FFFF, 1'b0);
      send_item(ita_pkg::CMD_UDEC, 64'hABCD_EF01_8000_0000, 1'b0);
      send_item(ita_pkg::CMD_UDEC, 64'd9, 1'b1);
      send_item(ita_pkg::CMD_UDEC, 64'd10, 1'b0);
      // Lower hex, zero without prefix, full width
      send_item(ita_pkg::CMD_LHEX, 64'd0, 1'b1);
      send_item(ita_pkg::CMD_LHEX, 64'd0, 1'b0);
      send_item(ita_pkg::CMD_LHEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(ita_pkg::CMD_LHEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_item(ita_pkg::CMD_LHEX, 64'h8000_0000_0000_0000, 1'b1);
      send_item(ita_pkg::CMD_LHEX, 64'd1, 1'b1);
      send_item(ita_pkg::CMD_LHEX, 64'h0123_4567_89AB_CDEF, 1'b0);
      // Upper hex keeps a lower-case prefix
      send_item(ita_pkg::CMD_UHEX, 64'd0, 1'b1);
      send_item(ita_pkg::CMD_UHEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(ita_pkg::CMD_UHEX, 64'hFEDC_BA98_7654_3210, 1'b0);
      send_item(ita_pkg::CMD_UHEX, 64'h0000_0000_DEAD_BEEF, 1'b1);
      send_item(ita_pkg::CMD_UHEX, 64'hF, 1'b0);
      send_item(ita_pkg::CMD_UHEX, 64'h10, 1'b1);
      pause_until_drained();

      // Random phases under different idle patterns
      for (int p = 0; p < 4; p++) begin
         req_idle_pct  = send_pct[p];
         rsp_stall_pct = recv_pct[p];
         if (p == 0) begin
            hold_req = 1'b1;
         end
         repeat (PHASE_ITEMS) begin
            send_item(2'($urandom_range(3)), rand_value(), 1'($urandom_range(1)));
         end
         pause_until_drained();
      end

      rsp_stall_pct = 0;
      if (text_sb.errors == 0 && text_sb.drained()) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/ita_pkg.sv
src/ita_front.sv
src/ita_queue.sv
src/ita_back.sv
src/integer_to_ascii_formatter.sv
tb/tb_integer_to_ascii_formatter.sv
